>>> hdl/lenode_pkg.sv
package lenode_pkg;

  localparam int unsigned MaxNodes  = 8;
  localparam int unsigned IdxW      = $clog2(MaxNodes);
  localparam int unsigned CntW      = $clog2(MaxNodes + 1);
  localparam int unsigned IdW       = 64;
  localparam int unsigned TermW     = 32;
  localparam int unsigned BaseW     = 16;
  localparam int unsigned CountW    = 17;
  localparam int unsigned LfsrW     = 16;
  localparam int unsigned InDataW   = 168;
  localparam int unsigned OutDataW  = 296;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [LfsrW-1:0]  LfsrSeed   = 16'hACE1;
  localparam logic [LfsrW-1:0]  LfsrTaps   = 16'hB400;
  // 1.5 in the 17-bit fraction format of the jitter multiply.
  localparam logic [17:0]       JitterBase = 18'd196608;
  localparam logic [TermW-1:0]  TermMax    = '1;
  localparam logic [3:0]        NoLeader   = 4'd15;

  // Input operations, carried in tuser. The last code is not an operation and is ignored.
  typedef enum logic [2:0] {
    OP_JOIN     = 3'd0,
    OP_JOIN_REQ = 3'd1,
    OP_MEMBER   = 3'd2,
    OP_VOTE_REQ = 3'd3,
    OP_VOTE_RSP = 3'd4,
    OP_HEART    = 3'd5,
    OP_TICK     = 3'd6,
    OP_NONE     = 3'd7
  } op_e;

  // Outgoing message kinds.
  typedef enum logic [2:0] {
    MSG_JOIN_REQ = 3'd0,
    MSG_MEMBERS  = 3'd1,
    MSG_VOTE_REQ = 3'd2,
    MSG_VOTE_RSP = 3'd3,
    MSG_HEART    = 3'd4
  } msg_e;

  typedef enum logic [1:0] {
    ROLE_BOOT   = 2'd0,
    ROLE_FOLLOW = 2'd1,
    ROLE_CAND   = 2'd2,
    ROLE_LEAD   = 2'd3
  } role_e;

  // How the results of one item are generated.
  typedef enum logic [1:0] {
    EM_NONE    = 2'd0,
    EM_SINGLE  = 2'd1,
    EM_BCAST   = 2'd2,
    EM_MEMBERS = 2'd3
  } emit_e;

  typedef enum logic [1:0] {
    CFG_EXPECTED = 2'd0,
    CFG_SELF_HI  = 2'd1,
    CFG_SELF_LO  = 2'd2,
    CFG_BASE     = 2'd3
  } cfg_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_APPLY = 7'b0000100,
    ST_TIMER = 7'b0001000,
    ST_START = 7'b0010000,
    ST_LOADD = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

endpackage

>>> hdl/leader_election_node_top.sv
// Flow: an accepted beat is scanned against the table, applied, passes the timer step
// when a non-leader timeout restarts, then the start step; one result beat per cycle
// leaves the output register while the sink is ready, save for the destination load step
// before each destination's membership update. One item at a time: the input is ready only while idle.
// Reset (rst_ni low, asynchronous): bootstrap role, term 0, one member (self),
// no voters, countdown 0, jitter LFSR 0xACE1, configuration at its defaults.
module leader_election_node_top import lenode_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [IdW-1:0]      cfg_data_i,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: peer_high, peer_low, term_in, granted_in, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic [2:0]          s_axis_tuser,
  // Output stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: dest_high, dest_low, term_out, granted_out, member_high, member_low,
  //        end_of_message, role_now, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: message_kind
  output logic [2:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  // Configuration registers.
  logic [3:0]       expected_q;
  logic [IdW-1:0]   self_hi_q, self_lo_q;
  logic [BaseW-1:0] base_q;

  // Node state.
  logic [IdW-1:0]    mem_hi_q [MaxNodes];
  logic [IdW-1:0]    mem_lo_q [MaxNodes];
  logic [IdW-1:0]    vot_hi_q [MaxNodes];
  logic [IdW-1:0]    vot_lo_q [MaxNodes];
  logic [CntW-1:0]   mt_q, vt_q;
  role_e             role_q;
  logic [TermW-1:0]  term_q;
  logic [3:0]        leader_q;
  logic [CountW-1:0] count_q;
  logic [LfsrW-1:0]  lfsr_q;

  // Latched item.
  logic [2:0]       op_q;
  logic [IdW-1:0]   peer_hi_q, peer_lo_q;
  logic [TermW-1:0] tin_q;
  logic             gin_q;

  // Sequencer.
  state_e           state_q;
  logic [IdxW-1:0]  k_q, i_q, j_q;
  logic             found_q;
  emit_e            mode_q;
  msg_e             kind_q;
  logic [TermW-1:0] eterm_q;
  logic             egrant_q;
  logic [IdW-1:0]   dest_hi_q, dest_lo_q;

  // Output register.
  logic             ovalid_q;
  logic [IdW-1:0]   o_dhi_q, o_dlo_q, o_mhi_q, o_mlo_q;
  logic [TermW-1:0] o_term_q;
  logic             o_gr_q, o_eom_q, o_last_q;
  logic [2:0]       o_kind_q;
  role_e            o_role_q;

  logic             in_fire, out_free;
  logic [IdxW-1:0]  rd_idx;
  logic [IdW-1:0]   rd_hi, rd_lo;
  logic             scan_vot, scan_hit;
  logic [CntW-1:0]  scan_tot;
  logic [CntW-1:0]  mt_m1;
  logic [LfsrW-1:0] lfsr_step;
  logic [33:0]      jit_prod;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !ovalid_q || m_axis_tready;
  assign mt_m1         = mt_q - CntW'(1);

  // Single read port of the member table; slot zero is this node.
  always_comb begin
    if (state_q == ST_SCAN) begin
      rd_idx = k_q;
    end else if (state_q == ST_LOADD || mode_q == EM_BCAST) begin
      rd_idx = i_q;
    end else begin
      rd_idx = j_q;
    end
    rd_hi = (rd_idx == '0) ? self_hi_q : mem_hi_q[rd_idx];
    rd_lo = (rd_idx == '0) ? self_lo_q : mem_lo_q[rd_idx];
  end

  // Compare one table entry per scan cycle.
  assign scan_vot = (op_q == OP_VOTE_RSP);
  assign scan_tot = scan_vot ? vt_q : mt_q;
  assign scan_hit = scan_vot ? (vot_hi_q[k_q] == peer_hi_q && vot_lo_q[k_q] == peer_lo_q)
                             : (rd_hi == peer_hi_q && rd_lo == peer_lo_q);

  // Galois LFSR step and jitter multiply for the timeout restart.
  assign lfsr_step = lfsr_q[0] ? ((lfsr_q >> 1) ^ LfsrTaps) : (lfsr_q >> 1);
  assign jit_prod  = 34'(base_q) * 34'(JitterBase + 18'(lfsr_q));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= 4'd1;
      self_hi_q  <= '0;
      self_lo_q  <= '0;
      base_q     <= BaseW'(1000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPECTED: expected_q <= cfg_data_i[3:0];
        CFG_SELF_HI:  self_hi_q  <= cfg_data_i;
        CFG_SELF_LO:  self_lo_q  <= cfg_data_i;
        CFG_BASE:     base_q     <= cfg_data_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= s_axis_tuser;
      peer_hi_q <= s_axis_tdata[63:0];
      peer_lo_q <= s_axis_tdata[127:64];
      tin_q     <= s_axis_tdata[159:128];
      gin_q     <= s_axis_tdata[160];
    end
  end

  // Table storage: entries are written only at the fill counts.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_APPLY) begin
      if ((op_q == OP_JOIN || op_q == OP_JOIN_REQ || op_q == OP_MEMBER)
          && !found_q && mt_q < CntW'(MaxNodes)) begin
        mem_hi_q[mt_q[IdxW-1:0]] <= peer_hi_q;
        mem_lo_q[mt_q[IdxW-1:0]] <= peer_lo_q;
      end
      if (op_q == OP_VOTE_RSP && tin_q == term_q && gin_q && !found_q
          && vt_q < CntW'(MaxNodes)) begin
        vot_hi_q[vt_q[IdxW-1:0]] <= peer_hi_q;
        vot_lo_q[vt_q[IdxW-1:0]] <= peer_lo_q;
      end
    end
  end

  // Sequencer and node state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [CntW-1:0]   vt_new;
    logic [CountW-1:0] cnt_dec;
    logic              restart;
    role_e             role_new;
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mt_q      <= CntW'(1);
      vt_q      <= '0;
      role_q    <= ROLE_BOOT;
      term_q    <= '0;
      leader_q  <= NoLeader;
      count_q   <= '0;
      lfsr_q    <= LfsrSeed;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      found_q   <= 1'b0;
      mode_q    <= EM_NONE;
      kind_q    <= MSG_JOIN_REQ;
      eterm_q   <= '0;
      egrant_q  <= 1'b0;
      dest_hi_q <= '0;
      dest_lo_q <= '0;
    end else begin
      vt_new   = vt_q;
      cnt_dec  = (count_q != '0) ? count_q - CountW'(1) : '0;
      restart  = 1'b0;
      role_new = role_q;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            k_q     <= '0;
            found_q <= 1'b0;
            state_q <= ST_SCAN;
          end
        end

        // Search the member or voter table for the peer.
        ST_SCAN: begin
          if (scan_tot == '0) begin
            state_q <= ST_APPLY;
          end else if (scan_hit) begin
            found_q <= 1'b1;
            state_q <= ST_APPLY;
          end else if ({1'b0, k_q} == scan_tot - CntW'(1)) begin
            state_q <= ST_APPLY;
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end

        // Update the state for this item and choose its results.
        ST_APPLY: begin
          mode_q   <= EM_NONE;
          egrant_q <= 1'b0;
          eterm_q  <= '0;
          case (op_q)
            OP_JOIN, OP_JOIN_REQ, OP_MEMBER: begin
              if (!found_q && mt_q < CntW'(MaxNodes)) begin
                mt_q <= mt_q + CntW'(1);
              end
              if (op_q == OP_JOIN) begin
                mode_q <= EM_SINGLE;
                kind_q <= MSG_JOIN_REQ;
              end else if (op_q == OP_JOIN_REQ) begin
                mode_q <= EM_MEMBERS;
                kind_q <= MSG_MEMBERS;
              end
            end
            OP_VOTE_REQ: begin
              mode_q  <= EM_SINGLE;
              kind_q  <= MSG_VOTE_RSP;
              eterm_q <= tin_q;
              if (tin_q > term_q) begin
                term_q   <= tin_q;
                egrant_q <= 1'b1;
              end
            end
            OP_VOTE_RSP: begin
              if (tin_q == term_q && gin_q) begin
                if (!found_q && vt_q < CntW'(MaxNodes)) begin
                  vt_new = vt_q + CntW'(1);
                end
                vt_q <= vt_new;
                if (role_q == ROLE_CAND
                    && {vt_new + CntW'(1), 1'b0} > {1'b0, mt_q}) begin
                  role_new = ROLE_LEAD;
                  leader_q <= '0;
                  mode_q   <= EM_BCAST;
                  kind_q   <= MSG_HEART;
                  eterm_q  <= term_q;
                  restart  = 1'b1;
                end
              end
            end
            OP_HEART: begin
              if (tin_q >= term_q) begin
                term_q   <= tin_q;
                role_new = ROLE_FOLLOW;
                leader_q <= found_q ? {1'b0, k_q} : NoLeader;
                restart  = 1'b1;
              end
            end
            OP_TICK: begin
              count_q <= cnt_dec;
              if (cnt_dec == '0) begin
                restart = 1'b1;
                if (role_q == ROLE_LEAD) begin
                  mode_q  <= EM_BCAST;
                  kind_q  <= MSG_HEART;
                  eterm_q <= term_q;
                end else if (role_q == ROLE_BOOT && mt_q != expected_q) begin
                  mode_q <= EM_MEMBERS;
                  kind_q <= MSG_MEMBERS;
                end else begin
                  // Election: new term unless the term is at its maximum, empty voter table, vote requests.
                  role_new = ROLE_CAND;
                  vt_q     <= '0;
                  mode_q   <= EM_BCAST;
                  kind_q   <= MSG_VOTE_REQ;
                  if (term_q != TermMax) begin
                    term_q  <= term_q + TermW'(1);
                    eterm_q <= term_q + TermW'(1);
                  end else begin
                    eterm_q <= term_q;
                  end
                end
              end
            end
            default: ;
          endcase
          role_q <= role_new;
          if (restart && role_new == ROLE_LEAD) begin
            count_q <= CountW'(base_q);
            state_q <= ST_START;
          end else if (restart) begin
            lfsr_q  <= lfsr_step;
            state_q <= ST_TIMER;
          end else begin
            state_q <= ST_START;
          end
        end

        // Randomized timeout from the stepped LFSR, for every role but leader.
        ST_TIMER: begin
          count_q <= jit_prod[33:17];
          state_q <= ST_START;
        end

        ST_START: begin
          i_q <= IdxW'(1);
          j_q <= '0;
          case (mode_q)
            EM_SINGLE:  state_q <= ST_EMIT;
            EM_BCAST:   state_q <= (mt_q > CntW'(1)) ? ST_EMIT : ST_IDLE;
            EM_MEMBERS: state_q <= (mt_q > CntW'(1)) ? ST_LOADD : ST_IDLE;
            default:    state_q <= ST_IDLE;
          endcase
        end

        // Hold the destination of one membership update.
        ST_LOADD: begin
          dest_hi_q <= rd_hi;
          dest_lo_q <= rd_lo;
          j_q       <= '0;
          state_q   <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            case (mode_q)
              EM_BCAST: begin
                if ({1'b0, i_q} == mt_m1) begin
                  state_q <= ST_IDLE;
                end else begin
                  i_q <= i_q + IdxW'(1);
                end
              end
              EM_MEMBERS: begin
                if ({1'b0, j_q} == mt_m1) begin
                  if ({1'b0, i_q} == mt_m1) begin
                    state_q <= ST_IDLE;
                  end else begin
                    i_q     <= i_q + IdxW'(1);
                    state_q <= ST_LOADD;
                  end
                end else begin
                  j_q <= j_q + IdxW'(1);
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Output register: payload of one result beat.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      o_kind_q <= kind_q;
      o_term_q <= eterm_q;
      o_gr_q   <= egrant_q;
      o_role_q <= role_q;
      case (mode_q)
        EM_BCAST: begin
          o_dhi_q  <= rd_hi;
          o_dlo_q  <= rd_lo;
          o_mhi_q  <= '0;
          o_mlo_q  <= '0;
          o_eom_q  <= 1'b1;
          o_last_q <= ({1'b0, i_q} == mt_m1);
        end
        EM_MEMBERS: begin
          o_dhi_q  <= dest_hi_q;
          o_dlo_q  <= dest_lo_q;
          o_mhi_q  <= rd_hi;
          o_mlo_q  <= rd_lo;
          o_eom_q  <= ({1'b0, j_q} == mt_m1);
          o_last_q <= ({1'b0, j_q} == mt_m1) && ({1'b0, i_q} == mt_m1);
        end
        default: begin
          o_dhi_q  <= peer_hi_q;
          o_dlo_q  <= peer_lo_q;
          o_mhi_q  <= '0;
          o_mlo_q  <= '0;
          o_eom_q  <= 1'b1;
          o_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {4'b0, o_role_q, o_eom_q, o_mlo_q, o_mhi_q, o_gr_q, o_term_q,
                          o_dlo_q, o_dhi_q};

  // The member count always covers self and never exceeds the table.
  a_member_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mt_q >= CntW'(1) && mt_q <= CntW'(MaxNodes))
    else $error("member count out of range");

  a_voter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vt_q <= CntW'(MaxNodes))
    else $error("voter count out of range");

  // A leader always records itself as leader.
  a_leader_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    role_q == ROLE_LEAD |-> leader_q == '0)
    else $error("leader without own slot");

  // A result beat only appears right after the sequencer was in the emit phase.
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !$past(ovalid_q) |-> $past(state_q) == ST_EMIT)
    else $error("result beat outside emit phase");

endmodule
